### sv/scalar_kalman_filter_step_defines.svh
// ----------------------------------------------------------------------------
// Scalar Kalman filter step: assertion macros
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SCALAR_KALMAN_FILTER_STEP_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_STEP_DEFINES_SVH

// same-cycle implication
`define SKFS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SKFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/skfs_pkg.sv
// ----------------------------------------------------------------------------
// skfs_pkg
// Types, constants, saturation helpers and the microcode program.
// ----------------------------------------------------------------------------
`default_nettype none

package skfs_pkg;

    localparam int DATA_WIDTH      = 32;
    localparam int FRAC_BITS       = 16;
    localparam int PROD_WIDTH      = 2 * DATA_WIDTH;
    localparam int NOISE_WIDTH     = 31;
    localparam int REG_INDEX_WIDTH = 3;
    localparam int IN_TDATA_WIDTH  = 2 * DATA_WIDTH;
    localparam int OUT_TDATA_WIDTH = 3 * DATA_WIDTH;

    // divider: dividend is num scaled by 2^FRAC_BITS, two quotient bits a cycle
    localparam int DVD_WIDTH       = DATA_WIDTH + FRAC_BITS;
    localparam int DIV_BITS_PER_CY = 2;
    localparam int DIV_CYCLES      = DVD_WIDTH / DIV_BITS_PER_CY;
    localparam int DIV_CNT_WIDTH   = $clog2(DIV_CYCLES + 1);

    localparam int PC_WIDTH        = 5;

    typedef logic signed [DATA_WIDTH-1:0] word_t;
    typedef logic signed [PROD_WIDTH-1:0] prod_t;
    typedef logic [DATA_WIDTH:0]          sum_t;
    typedef logic [NOISE_WIDTH-1:0]       noise_t;
    typedef logic [REG_INDEX_WIDTH-1:0]   reg_index_t;
    typedef logic [PC_WIDTH-1:0]          pc_t;

    localparam word_t WORD_MAX   = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam word_t WORD_MIN   = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam word_t ONE_Q      = word_t'(1 << FRAC_BITS);
    localparam prod_t ROUND_HALF = prod_t'(1) << (FRAC_BITS - 1);

    localparam word_t COEF_RESET  = word_t'(65536);
    localparam noise_t NOISE_RESET = noise_t'(6554);

    // configuration register indexes
    localparam reg_index_t REG_COEF_A     = 3'd0;
    localparam reg_index_t REG_COEF_B     = 3'd1;
    localparam reg_index_t REG_COEF_C     = 3'd2;
    localparam reg_index_t REG_PROC_NOISE = 3'd3;
    localparam reg_index_t REG_MEAS_NOISE = 3'd4;

    typedef enum logic [3:0] {
        UOP_NOP   = 4'd0,
        UOP_LOAD  = 4'd1,
        UOP_MUL   = 4'd2,
        UOP_MWB   = 4'd3,
        UOP_ADD   = 4'd4,
        UOP_SUB   = 4'd5,
        UOP_DIVGO = 4'd6,
        UOP_DIVWB = 4'd7,
        UOP_DONE  = 4'd8
    } uop_t;

    typedef enum logic [3:0] {
        SRC_A    = 4'd0,
        SRC_B    = 4'd1,
        SRC_C    = 4'd2,
        SRC_Q    = 4'd3,
        SRC_R    = 4'd4,
        SRC_U    = 4'd5,
        SRC_Z    = 4'd6,
        SRC_MEAN = 4'd7,
        SRC_VAR  = 4'd8,
        SRC_ONE  = 4'd9,
        SRC_PM   = 4'd10,
        SRC_PV   = 4'd11,
        SRC_NUM  = 4'd12,
        SRC_DEN  = 4'd13,
        SRC_GAIN = 4'd14,
        SRC_X1   = 4'd15
    } src_t;

    typedef enum logic [3:0] {
        DST_NONE = 4'd0,
        DST_PM   = 4'd1,
        DST_PV   = 4'd2,
        DST_NUM  = 4'd3,
        DST_DEN  = 4'd4,
        DST_GAIN = 4'd5,
        DST_X1   = 4'd6,
        DST_MEAN = 4'd7,
        DST_VAR  = 4'd8
    } dst_t;

    // jump conditions; the waiting ones jump to their own step and hold the op
    typedef enum logic [2:0] {
        JC_NEXT     = 3'd0,
        JC_ALWAYS   = 3'd1,
        JC_NO_INPUT = 3'd2,
        JC_DIV_BUSY = 3'd3,
        JC_OUT_FULL = 3'd4
    } jc_t;

    typedef struct packed {
        uop_t op;
        dst_t dst;
        src_t srca;
        src_t srcb;
        jc_t  jc;
        pc_t  target;
    } uword_t;

    typedef struct packed {
        uword_t word;
        logic   fire;
    } seq_ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic div_busy;
        logic out_full;
    } seq_stat_t;

    localparam pc_t PC_LOAD     = 5'd0;
    localparam pc_t PC_DIV_WAIT = 5'd19;
    localparam pc_t PC_DONE     = 5'd31;

    function automatic word_t sat_prod(input prod_t x);
        logic [PROD_WIDTH-DATA_WIDTH:0] hi;
        hi = x[PROD_WIDTH-1:DATA_WIDTH-1];
        if ((&hi) || !(|hi))
            return word_t'(x[DATA_WIDTH-1:0]);
        else if (x[PROD_WIDTH-1])
            return WORD_MIN;
        else
            return WORD_MAX;
    endfunction

    function automatic word_t sat_sum(input sum_t x);
        if (x[DATA_WIDTH] == x[DATA_WIDTH-1])
            return word_t'(x[DATA_WIDTH-1:0]);
        else if (x[DATA_WIDTH])
            return WORD_MIN;
        else
            return WORD_MAX;
    endfunction

    function automatic uword_t uw(input uop_t op, input dst_t dst, input src_t sa,
                                  input src_t sb, input jc_t jc, input pc_t tgt);
        uword_t w;
        w = '{op: op, dst: dst, srca: sa, srcb: sb, jc: jc, target: tgt};
        return w;
    endfunction

    // one step of the filter, one control word per step
    function automatic uword_t ucode(input pc_t pc);
        uword_t w;
        case (pc)
            5'd0:  w = uw(UOP_LOAD,  DST_NONE, SRC_U,    SRC_Z,    JC_NO_INPUT, PC_LOAD);
            // pm = a*mean + b*u
            5'd1:  w = uw(UOP_MUL,   DST_NONE, SRC_A,    SRC_MEAN, JC_NEXT, PC_LOAD);
            5'd2:  w = uw(UOP_MWB,   DST_X1,   SRC_A,    SRC_A,    JC_NEXT, PC_LOAD);
            5'd3:  w = uw(UOP_MUL,   DST_NONE, SRC_B,    SRC_U,    JC_NEXT, PC_LOAD);
            5'd4:  w = uw(UOP_MWB,   DST_PM,   SRC_A,    SRC_A,    JC_NEXT, PC_LOAD);
            5'd5:  w = uw(UOP_ADD,   DST_PM,   SRC_X1,   SRC_PM,   JC_NEXT, PC_LOAD);
            // pv = (a*var)*a + q
            5'd6:  w = uw(UOP_MUL,   DST_NONE, SRC_A,    SRC_VAR,  JC_NEXT, PC_LOAD);
            5'd7:  w = uw(UOP_MWB,   DST_X1,   SRC_A,    SRC_A,    JC_NEXT, PC_LOAD);
            5'd8:  w = uw(UOP_MUL,   DST_NONE, SRC_X1,   SRC_A,    JC_NEXT, PC_LOAD);
            5'd9:  w = uw(UOP_MWB,   DST_X1,   SRC_A,    SRC_A,    JC_NEXT, PC_LOAD);
            5'd10: w = uw(UOP_ADD,   DST_PV,   SRC_X1,   SRC_Q,    JC_NEXT, PC_LOAD);
            // num = pv*c, den = (c*pv)*c + r
            5'd11: w = uw(UOP_MUL,   DST_NONE, SRC_PV,   SRC_C,    JC_NEXT, PC_LOAD);
            5'd12: w = uw(UOP_MWB,   DST_NUM,  SRC_A,    SRC_A,    JC_NEXT, PC_LOAD);
            5'd13: w = uw(UOP_MUL,   DST_NONE, SRC_C,    SRC_PV,   JC_NEXT, PC_LOAD);
            5'd14: w = uw(UOP_MWB,   DST_X1,   SRC_A,    SRC_A,    JC_NEXT, PC_LOAD);
            5'd15: w = uw(UOP_MUL,   DST_NONE, SRC_X1,   SRC_C,    JC_NEXT, PC_LOAD);
            5'd16: w = uw(UOP_MWB,   DST_X1,   SRC_A,    SRC_A,    JC_NEXT, PC_LOAD);
            5'd17: w = uw(UOP_ADD,   DST_DEN,  SRC_X1,   SRC_R,    JC_NEXT, PC_LOAD);
            // gain = num / den
            5'd18: w = uw(UOP_DIVGO, DST_NONE, SRC_NUM,  SRC_DEN,  JC_NEXT, PC_LOAD);
            5'd19: w = uw(UOP_DIVWB, DST_GAIN, SRC_A,    SRC_A,    JC_DIV_BUSY, PC_DIV_WAIT);
            // mean' = pm + gain*(z - c*pm)
            5'd20: w = uw(UOP_MUL,   DST_NONE, SRC_C,    SRC_PM,   JC_NEXT, PC_LOAD);
            5'd21: w = uw(UOP_MWB,   DST_X1,   SRC_A,    SRC_A,    JC_NEXT, PC_LOAD);
            5'd22: w = uw(UOP_SUB,   DST_X1,   SRC_Z,    SRC_X1,   JC_NEXT, PC_LOAD);
            5'd23: w = uw(UOP_MUL,   DST_NONE, SRC_GAIN, SRC_X1,   JC_NEXT, PC_LOAD);
            5'd24: w = uw(UOP_MWB,   DST_X1,   SRC_A,    SRC_A,    JC_NEXT, PC_LOAD);
            5'd25: w = uw(UOP_ADD,   DST_MEAN, SRC_PM,   SRC_X1,   JC_NEXT, PC_LOAD);
            // var' = (1 - gain*c) * pv
            5'd26: w = uw(UOP_MUL,   DST_NONE, SRC_GAIN, SRC_C,    JC_NEXT, PC_LOAD);
            5'd27: w = uw(UOP_MWB,   DST_X1,   SRC_A,    SRC_A,    JC_NEXT, PC_LOAD);
            5'd28: w = uw(UOP_SUB,   DST_X1,   SRC_ONE,  SRC_X1,   JC_NEXT, PC_LOAD);
            5'd29: w = uw(UOP_MUL,   DST_NONE, SRC_X1,   SRC_PV,   JC_NEXT, PC_LOAD);
            5'd30: w = uw(UOP_MWB,   DST_VAR,  SRC_A,    SRC_A,    JC_NEXT, PC_LOAD);
            5'd31: w = uw(UOP_DONE,  DST_NONE, SRC_A,    SRC_A,    JC_OUT_FULL, PC_DONE);
            default: w = uw(UOP_NOP, DST_NONE, SRC_A,    SRC_A,    JC_ALWAYS, PC_LOAD);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### sv/scalar_kalman_filter_step.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter_step
// One-dimensional Kalman filter step in signed Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input words on s_axis: control value and observation. Each accepted word
//   runs one predict/update step against the kept mean and variance and
//   yields one result word on m_axis: new mean, new variance and gain.
//   The cfg channel writes coefficients and noise terms by index; it is
//   always ready and is meant to be written while no word is in flight.
//   The next input word is accepted only once the last one's program is
//   back on its load step. The divider works two quotient bits a cycle over
//   a 48-bit scaled dividend; the other microcode steps run one per cycle,
//   unless held on a waiting step, through a single multiplier and adder.
//   Reset clears mean and variance to zero and loads the coefficient
//   defaults (a = b = c = 1.0, q = r = 6554).
//   The result sits in an output register; the next input word is accepted
//   while it waits. If the receiver still stalls when the next result is
//   done, the program holds on its final step until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none
`include "scalar_kalman_filter_step_defines.svh"

module scalar_kalman_filter_step (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    // control_value [31:0], observed_value [63:32]
    input  wire logic [skfs_pkg::IN_TDATA_WIDTH-1:0]     s_axis_tdata,
    input  wire logic                                    s_axis_tvalid,
    output logic                                         s_axis_tready,
    // new_mean [31:0], new_variance [63:32], gain_out [95:64]
    output logic [skfs_pkg::OUT_TDATA_WIDTH-1:0]         m_axis_tdata,
    output logic                                         m_axis_tvalid,
    input  wire logic                                    m_axis_tready,
    input  wire logic                                    cfg_valid,
    output logic                                         cfg_ready,
    input  wire logic [skfs_pkg::REG_INDEX_WIDTH-1:0]    cfg_index,
    input  wire logic [skfs_pkg::DATA_WIDTH-1:0]         cfg_data
);

    localparam int DW = skfs_pkg::DATA_WIDTH;

    skfs_pkg::seq_ctrl_t ctrl;
    skfs_pkg::seq_stat_t stat;
    skfs_pkg::word_t     mean;
    skfs_pkg::word_t     variance;
    skfs_pkg::word_t     gain;
    logic                div_busy;
    logic                done_fire;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [skfs_pkg::OUT_TDATA_WIDTH-1:0] out_data_reg;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (ctrl.word.op == skfs_pkg::UOP_LOAD);
    assign done_fire     = ctrl.fire && (ctrl.word.op == skfs_pkg::UOP_DONE);

    assign stat.in_valid = s_axis_tvalid;
    assign stat.div_busy = div_busy;
    assign stat.out_full = out_valid_reg && !m_axis_tready;

    skfs_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    skfs_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .control_value  (skfs_pkg::word_t'(s_axis_tdata[DW-1:0])),
        .observed_value (skfs_pkg::word_t'(s_axis_tdata[2*DW-1:DW])),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mean           (mean),
        .variance       (variance),
        .gain           (gain),
        .div_busy       (div_busy)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_axis_tready)
            out_valid_next = 1'b0;
        if (done_fire)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (done_fire)
            out_data_reg <= {gain, variance, mean};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `SKFS_ASSERT_NEXT(a_done_shows, done_fire, m_axis_tvalid, "finished result not presented")
    `SKFS_ASSERT_NOW(a_no_overwrite, done_fire, !(out_valid_reg && !m_axis_tready), "pending result overwritten")
    `SKFS_ASSERT_NOW(a_load_div_idle, s_axis_tready, !div_busy, "input taken while divider busy")
    `SKFS_ASSERT_NEXT(a_one_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second word taken mid-step")

endmodule

`default_nettype wire

### sv/skfs_sequencer.sv
// ----------------------------------------------------------------------------
// skfs_sequencer
// Step counter over the microcode table with conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module skfs_sequencer (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire skfs_pkg::seq_stat_t   stat,
    output skfs_pkg::seq_ctrl_t        ctrl
);

    skfs_pkg::pc_t    pc_reg;
    skfs_pkg::pc_t    pc_next;
    skfs_pkg::uword_t word;
    logic             cond;

    assign word = skfs_pkg::ucode(pc_reg);

    always_comb
    begin
        unique case (word.jc)
            skfs_pkg::JC_NEXT:     cond = 1'b0;
            skfs_pkg::JC_ALWAYS:   cond = 1'b1;
            skfs_pkg::JC_NO_INPUT: cond = !stat.in_valid;
            skfs_pkg::JC_DIV_BUSY: cond = stat.div_busy;
            skfs_pkg::JC_OUT_FULL: cond = stat.out_full;
            default:               cond = 1'b0;
        endcase
    end

    // a waiting step only executes once its condition clears
    assign ctrl.word = word;
    assign ctrl.fire = !cond || (word.jc == skfs_pkg::JC_ALWAYS);

    always_comb
    begin
        if (cond)
            pc_next = word.target;
        else if (word.op == skfs_pkg::UOP_DONE)
            pc_next = skfs_pkg::PC_LOAD;
        else
            pc_next = pc_reg + skfs_pkg::pc_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= skfs_pkg::PC_LOAD;
        else
            pc_reg <= pc_next;
    end

endmodule

`default_nettype wire

### sv/skfs_div.sv
// ----------------------------------------------------------------------------
// skfs_div
// Signed fixed-point divider: (num << FRAC_BITS) / den, truncated, saturated.
// Restoring, two quotient bits per cycle; zero divisor yields zero.
// ----------------------------------------------------------------------------
`default_nettype none
`include "scalar_kalman_filter_step_defines.svh"

module skfs_div (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire skfs_pkg::word_t num,
    input  wire skfs_pkg::word_t den,
    output logic               busy,
    output skfs_pkg::word_t    quot
);

    localparam int DW = skfs_pkg::DATA_WIDTH;
    localparam int VW = skfs_pkg::DVD_WIDTH;
    localparam logic [VW-1:0] MAG_POS_MAX = VW'({1'b0, {(DW-1){1'b1}}});
    localparam logic [VW-1:0] MAG_NEG_MAX = MAG_POS_MAX + VW'(1);

    logic                                busy_reg;
    logic [skfs_pkg::DIV_CNT_WIDTH-1:0]  cnt_reg;
    logic [DW-1:0]                       rem_reg;
    logic [DW-1:0]                       rem_next;
    logic [VW-1:0]                       quo_reg;
    logic [VW-1:0]                       quo_next;
    logic [DW-1:0]                       dvs_reg;
    logic                                neg_reg;
    logic                                zero_reg;
    logic [DW-1:0]                       abs_num;
    logic [DW-1:0]                       abs_den;

    assign abs_num = num[DW-1] ? (~num + DW'(1)) : num;
    assign abs_den = den[DW-1] ? (~den + DW'(1)) : den;

    always_comb
    begin
        logic [DW:0] trial;
        rem_next = rem_reg;
        quo_next = quo_reg;
        for (int i = 0; i < skfs_pkg::DIV_BITS_PER_CY; i++)
        begin
            trial = {rem_next, quo_next[VW-1]};
            if (trial >= {1'b0, dvs_reg})
            begin
                trial    = trial - {1'b0, dvs_reg};
                rem_next = trial[DW-1:0];
                quo_next = {quo_next[VW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_next[VW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            zero_reg <= 1'b1;
        end
        else if (start)
        begin
            busy_reg <= (den != '0);
            zero_reg <= (den == '0);
            cnt_reg  <= skfs_pkg::DIV_CNT_WIDTH'(skfs_pkg::DIV_CYCLES);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - skfs_pkg::DIV_CNT_WIDTH'(1);
            if (cnt_reg == skfs_pkg::DIV_CNT_WIDTH'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= {abs_num, {skfs_pkg::FRAC_BITS{1'b0}}};
            dvs_reg <= abs_den;
            neg_reg <= num[DW-1] ^ den[DW-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    always_comb
    begin
        if (zero_reg)
            quot = '0;
        else if (!neg_reg)
            quot = (quo_reg > MAG_POS_MAX) ? skfs_pkg::WORD_MAX
                                           : skfs_pkg::word_t'(quo_reg[DW-1:0]);
        else
            quot = (quo_reg > MAG_NEG_MAX) ? skfs_pkg::WORD_MIN
                                           : skfs_pkg::word_t'(~quo_reg[DW-1:0] + DW'(1));
    end

    assign busy = busy_reg;

    `SKFS_ASSERT_NEXT(a_div_runs, start && (den != '0), busy_reg, "divider did not start")
    `SKFS_ASSERT_NEXT(a_div_zero, start && (den == '0), !busy_reg && (quot == '0), "zero divisor must give zero at once")

endmodule

`default_nettype wire

### sv/skfs_dp.sv
// ----------------------------------------------------------------------------
// skfs_dp
// Datapath: coefficient registers, working registers, one multiplier with
// round/saturate writeback, saturating adder, and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module skfs_dp (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire skfs_pkg::seq_ctrl_t                    ctrl,
    input  wire skfs_pkg::word_t                        control_value,
    input  wire skfs_pkg::word_t                        observed_value,
    input  wire logic                                   cfg_we,
    input  wire logic [skfs_pkg::REG_INDEX_WIDTH-1:0]   cfg_index,
    input  wire logic [skfs_pkg::DATA_WIDTH-1:0]        cfg_data,
    output skfs_pkg::word_t                             mean,
    output skfs_pkg::word_t                             variance,
    output skfs_pkg::word_t                             gain,
    output logic                                        div_busy
);

    localparam int DW = skfs_pkg::DATA_WIDTH;

    skfs_pkg::word_t  coef_a_reg;
    skfs_pkg::word_t  coef_b_reg;
    skfs_pkg::word_t  coef_c_reg;
    skfs_pkg::noise_t proc_noise_reg;
    skfs_pkg::noise_t meas_noise_reg;
    skfs_pkg::word_t  mean_reg;
    skfs_pkg::word_t  variance_reg;
    skfs_pkg::word_t  u_reg;
    skfs_pkg::word_t  z_reg;
    skfs_pkg::word_t  pm_reg;
    skfs_pkg::word_t  pv_reg;
    skfs_pkg::word_t  num_reg;
    skfs_pkg::word_t  den_reg;
    skfs_pkg::word_t  gain_reg;
    skfs_pkg::word_t  x1_reg;
    skfs_pkg::prod_t  prod_reg;
    skfs_pkg::prod_t  prod_round;
    skfs_pkg::word_t  opa;
    skfs_pkg::word_t  opb;
    skfs_pkg::word_t  wr_data;
    skfs_pkg::word_t  div_quot;
    logic             wr_en;
    logic             div_start;
    skfs_pkg::uop_t   op;

    assign op = ctrl.word.op;

    function automatic skfs_pkg::word_t pick(input skfs_pkg::src_t s,
        input skfs_pkg::word_t a, input skfs_pkg::word_t b, input skfs_pkg::word_t c,
        input skfs_pkg::noise_t q, input skfs_pkg::noise_t r,
        input skfs_pkg::word_t u, input skfs_pkg::word_t z,
        input skfs_pkg::word_t m, input skfs_pkg::word_t v,
        input skfs_pkg::word_t pm, input skfs_pkg::word_t pv,
        input skfs_pkg::word_t nm, input skfs_pkg::word_t dn,
        input skfs_pkg::word_t g, input skfs_pkg::word_t x1);
        skfs_pkg::word_t w;
        unique case (s)
            skfs_pkg::SRC_A:    w = a;
            skfs_pkg::SRC_B:    w = b;
            skfs_pkg::SRC_C:    w = c;
            skfs_pkg::SRC_Q:    w = skfs_pkg::word_t'({1'b0, q});
            skfs_pkg::SRC_R:    w = skfs_pkg::word_t'({1'b0, r});
            skfs_pkg::SRC_U:    w = u;
            skfs_pkg::SRC_Z:    w = z;
            skfs_pkg::SRC_MEAN: w = m;
            skfs_pkg::SRC_VAR:  w = v;
            skfs_pkg::SRC_ONE:  w = skfs_pkg::ONE_Q;
            skfs_pkg::SRC_PM:   w = pm;
            skfs_pkg::SRC_PV:   w = pv;
            skfs_pkg::SRC_NUM:  w = nm;
            skfs_pkg::SRC_DEN:  w = dn;
            skfs_pkg::SRC_GAIN: w = g;
            skfs_pkg::SRC_X1:   w = x1;
            default:            w = '0;
        endcase
        return w;
    endfunction

    assign opa = pick(ctrl.word.srca, coef_a_reg, coef_b_reg, coef_c_reg,
                      proc_noise_reg, meas_noise_reg, u_reg, z_reg, mean_reg,
                      variance_reg, pm_reg, pv_reg, num_reg, den_reg, gain_reg, x1_reg);
    assign opb = pick(ctrl.word.srcb, coef_a_reg, coef_b_reg, coef_c_reg,
                      proc_noise_reg, meas_noise_reg, u_reg, z_reg, mean_reg,
                      variance_reg, pm_reg, pv_reg, num_reg, den_reg, gain_reg, x1_reg);

    // round half up, then floor shift
    assign prod_round = (prod_reg + skfs_pkg::ROUND_HALF) >>> skfs_pkg::FRAC_BITS;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_data = '0;
        case (op) inside
            skfs_pkg::UOP_MWB:
            begin
                wr_en   = ctrl.fire;
                wr_data = skfs_pkg::sat_prod(prod_round);
            end
            skfs_pkg::UOP_ADD:
            begin
                wr_en   = ctrl.fire;
                wr_data = skfs_pkg::sat_sum({opa[DW-1], opa} + {opb[DW-1], opb});
            end
            skfs_pkg::UOP_SUB:
            begin
                wr_en   = ctrl.fire;
                wr_data = skfs_pkg::sat_sum({opa[DW-1], opa} - {opb[DW-1], opb});
            end
            skfs_pkg::UOP_DIVWB:
            begin
                wr_en   = ctrl.fire;
                wr_data = div_quot;
            end
            default:
            begin
                wr_en   = 1'b0;
                wr_data = '0;
            end
        endcase
    end

    assign div_start = ctrl.fire && (op == skfs_pkg::UOP_DIVGO);

    skfs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (opa),
        .den   (opb),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg     <= skfs_pkg::COEF_RESET;
            coef_b_reg     <= skfs_pkg::COEF_RESET;
            coef_c_reg     <= skfs_pkg::COEF_RESET;
            proc_noise_reg <= skfs_pkg::NOISE_RESET;
            meas_noise_reg <= skfs_pkg::NOISE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                skfs_pkg::REG_COEF_A:     coef_a_reg     <= cfg_data;
                skfs_pkg::REG_COEF_B:     coef_b_reg     <= cfg_data;
                skfs_pkg::REG_COEF_C:     coef_c_reg     <= cfg_data;
                skfs_pkg::REG_PROC_NOISE: proc_noise_reg <= cfg_data[skfs_pkg::NOISE_WIDTH-1:0];
                skfs_pkg::REG_MEAS_NOISE: meas_noise_reg <= cfg_data[skfs_pkg::NOISE_WIDTH-1:0];
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg     <= '0;
            variance_reg <= '0;
        end
        else if (wr_en)
        begin
            if (ctrl.word.dst == skfs_pkg::DST_MEAN)
                mean_reg <= wr_data;
            if (ctrl.word.dst == skfs_pkg::DST_VAR)
                variance_reg <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.fire && (op == skfs_pkg::UOP_LOAD))
        begin
            u_reg <= control_value;
            z_reg <= observed_value;
        end
        if (ctrl.fire && (op == skfs_pkg::UOP_MUL))
            prod_reg <= opa * opb;
        if (wr_en)
        begin
            unique case (ctrl.word.dst)
                skfs_pkg::DST_PM:   pm_reg   <= wr_data;
                skfs_pkg::DST_PV:   pv_reg   <= wr_data;
                skfs_pkg::DST_NUM:  num_reg  <= wr_data;
                skfs_pkg::DST_DEN:  den_reg  <= wr_data;
                skfs_pkg::DST_GAIN: gain_reg <= wr_data;
                skfs_pkg::DST_X1:   x1_reg   <= wr_data;
                default:            ;
            endcase
        end
    end

    assign mean     = mean_reg;
    assign variance = variance_reg;
    assign gain     = gain_reg;

endmodule

`default_nettype wire
